// ----- src/fwq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwq_pkg: shared types and constants of the futex wait queue
// Request and result item layouts, operation codes, status codes and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package fwq_pkg;

    localparam int CMD_W       = 7;
    localparam int WORD_ADDR_W = 48;
    localparam int VALUE_W     = 32;
    localparam int TASK_W      = 8;
    localparam int COUNT_W     = 5;

    // Operation codes after the flag bits have been masked off.
    localparam logic [CMD_W-1:0] OP_WAIT        = 7'd0;
    localparam logic [CMD_W-1:0] OP_WAIT_BITSET = 7'd9;
    localparam logic [CMD_W-1:0] OP_WAKE        = 7'd1;
    localparam logic [CMD_W-1:0] OP_WAKE_BITSET = 7'd10;
    localparam logic [CMD_W-1:0] OP_REQUEUE     = 7'd3;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BADADDR = 2'd1,
        ST_AGAIN   = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        EM_NONE   = 2'd0,
        EM_STATUS = 2'd1,
        EM_TASK   = 2'd2,
        EM_COUNT  = 2'd3
    } emit_t;

    typedef struct packed {
        logic [CMD_W-1:0]       cmd;
        logic [WORD_ADDR_W-1:0] word_addr;
        logic signed [VALUE_W-1:0] word_value;
        logic signed [VALUE_W-1:0] arg_value;
        logic [TASK_W-1:0]      caller_task;
    } req_t;

    typedef struct packed {
        status_t              status;
        logic                 task_valid;
        logic [TASK_W-1:0]    woken_task;
        logic [COUNT_W-1:0]   woken_count;
        logic                 last;
    } rsp_t;

    // Controller to datapath.
    typedef struct packed {
        logic    load;        // capture the request
        logic    push;        // append the request at the newest end
        logic    scan_init;   // start the newest-to-oldest scan
        logic    scan_step;   // read the next older entry
        logic    scan_take;   // the entry just read is woken
        logic    cmp_init;    // start compaction at the lowest woken index
        logic    cmp_read;    // read the next entry to compact
        logic    cmp_write;   // write it back if it survives
        logic    occ_commit;  // occupancy drops by the woken count
        emit_t   emit;
        status_t code;
    } cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic addr_zero;
        logic is_wait;
        logic is_wake;
        logic val_eq;
        logic full;
        logic scan_done;
        logic hit;
        logic woken_zero;
        logic cmp_done;
    } sts_t;

endpackage

// ----- src/fwq_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwq_ctrl: sequencer of the futex wait queue
// Decodes each request and steps the datapath through the wake scan and
// the compaction pass that follows it.
// ----------------------------------------------------------------------------
module fwq_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  fwq_pkg::sts_t sts,
    output fwq_pkg::cmd_t cmd
);
    import fwq_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_DECODE   = 7'b0000010,
        S_SCAN_RD  = 7'b0000100,
        S_SCAN_CHK = 7'b0001000,
        S_CMP_RD   = 7'b0010000,
        S_CMP_WR   = 7'b0100000,
        S_FINAL    = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    assign busy = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        cmd.emit   = EM_NONE;
        cmd.code   = ST_OK;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_IDLE;
                priority if (sts.addr_zero)
                begin
                    cmd.emit = EM_STATUS;
                    cmd.code = ST_BADADDR;
                end
                else if (sts.is_wait)
                begin
                    cmd.emit = EM_STATUS;
                    priority if (!sts.val_eq)
                    begin
                        cmd.code = ST_AGAIN;
                    end
                    else if (sts.full)
                    begin
                        cmd.code = ST_FULL;
                    end
                    else
                    begin
                        cmd.push = 1'b1;
                        cmd.code = ST_OK;
                    end
                end
                else if (sts.is_wake)
                begin
                    cmd.scan_init = 1'b1;
                    state_next    = S_SCAN_RD;
                end
                else
                begin
                    cmd.emit = EM_STATUS;
                    cmd.code = ST_OK;
                end
            end
            S_SCAN_RD:
            begin
                priority if (sts.scan_done && sts.woken_zero)
                begin
                    state_next = S_FINAL;
                end
                else if (sts.scan_done)
                begin
                    cmd.cmp_init = 1'b1;
                    state_next   = S_CMP_RD;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                    state_next    = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK:
            begin
                if (sts.hit)
                begin
                    cmd.scan_take = 1'b1;
                    cmd.emit      = EM_TASK;
                end
                state_next = S_SCAN_RD;
            end
            S_CMP_RD:
            begin
                if (sts.cmp_done)
                begin
                    cmd.occ_commit = 1'b1;
                    state_next     = S_FINAL;
                end
                else
                begin
                    cmd.cmp_read = 1'b1;
                    state_next   = S_CMP_WR;
                end
            end
            S_CMP_WR:
            begin
                cmd.cmp_write = 1'b1;
                state_next    = S_CMP_RD;
            end
            S_FINAL:
            begin
                cmd.emit   = EM_COUNT;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- src/fwq_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwq_datapath: waiter table and counters of the futex wait queue
// Holds the captured request, the ordered waiter memory, the scan and
// compaction indexes and the result register.
// ----------------------------------------------------------------------------
module fwq_datapath #(
    parameter int MAX_WAITERS = 16,
    parameter int ADDR_BITS   = 48
) (
    input  logic          clk,
    input  logic          rst_n,
    input  fwq_pkg::req_t req,
    input  fwq_pkg::cmd_t cmd,
    output fwq_pkg::sts_t sts,
    output logic          valid,
    output fwq_pkg::rsp_t rsp
);
    import fwq_pkg::*;

    localparam int IDX_W = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
    localparam int CNT_W = $clog2(MAX_WAITERS + 1);

    logic [ADDR_BITS-1:0] addr_in;

    // Captured request.
    logic [CMD_W-1:0]          cmd_reg;
    logic [ADDR_BITS-1:0]      addr_reg;
    logic signed [VALUE_W-1:0] wval_reg;
    logic signed [VALUE_W-1:0] aval_reg;
    logic [TASK_W-1:0]         task_reg;

    // Waiter table; entry 0 is the oldest.
    logic [ADDR_BITS-1:0] mem_addr [MAX_WAITERS];
    logic [TASK_W-1:0]    mem_task [MAX_WAITERS];
    logic [ADDR_BITS-1:0] rd_addr_reg;
    logic [TASK_W-1:0]    rd_task_reg;

    logic [CNT_W-1:0] occ_reg;
    logic [CNT_W-1:0] i_reg;
    logic [CNT_W-1:0] woken_reg;
    logic [CNT_W-1:0] low_reg;
    logic [CNT_W-1:0] r_reg;
    logic [CNT_W-1:0] w_reg;
    logic [CNT_W-1:0] i_dec;

    logic                 we;
    logic [IDX_W-1:0]     waddr;
    logic [ADDR_BITS-1:0] wdata_addr;
    logic [TASK_W-1:0]    wdata_task;
    logic                 re;
    logic [IDX_W-1:0]     raddr;
    logic [VALUE_W-1:0]   woken_wide;

    logic          valid_reg;
    rsp_t          rsp_reg;

    // Addresses are kept and compared within their low ADDR_BITS bits.
    generate
        if (ADDR_BITS <= WORD_ADDR_W)
        begin : g_addr_trunc
            assign addr_in = req.word_addr[ADDR_BITS-1:0];
        end
        else
        begin : g_addr_ext
            assign addr_in = {{(ADDR_BITS-WORD_ADDR_W){1'b0}}, req.word_addr};
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg  <= req.cmd;
            addr_reg <= addr_in;
            wval_reg <= req.word_value;
            aval_reg <= req.arg_value;
            task_reg <= req.caller_task;
        end
    end

    assign i_dec      = i_reg - 1'b1;
    assign woken_wide = {{(VALUE_W-CNT_W){1'b0}}, woken_reg};

    // Memory port selection.
    always_comb
    begin
        we         = 1'b0;
        waddr      = occ_reg[IDX_W-1:0];
        wdata_addr = addr_reg;
        wdata_task = task_reg;
        if (cmd.push)
        begin
            we = 1'b1;
        end
        else if (cmd.cmp_write && !sts.hit)
        begin
            we         = 1'b1;
            waddr      = w_reg[IDX_W-1:0];
            wdata_addr = rd_addr_reg;
            wdata_task = rd_task_reg;
        end
        re    = cmd.scan_step | cmd.cmp_read;
        raddr = cmd.scan_step ? i_dec[IDX_W-1:0] : r_reg[IDX_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_addr[waddr] <= wdata_addr;
            mem_task[waddr] <= wdata_task;
        end
        if (re)
        begin
            rd_addr_reg <= mem_addr[raddr];
            rd_task_reg <= mem_task[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else if (cmd.push)
        begin
            occ_reg <= occ_reg + 1'b1;
        end
        else if (cmd.occ_commit)
        begin
            occ_reg <= occ_reg - woken_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_init)
        begin
            i_reg     <= occ_reg;
            woken_reg <= '0;
            low_reg   <= occ_reg;
        end
        if (cmd.scan_step)
        begin
            i_reg <= i_dec;
        end
        if (cmd.scan_take)
        begin
            woken_reg <= woken_reg + 1'b1;
            low_reg   <= i_reg;
        end
        if (cmd.cmp_init)
        begin
            r_reg <= low_reg;
            w_reg <= low_reg;
        end
        if (cmd.cmp_read)
        begin
            r_reg <= r_reg + 1'b1;
        end
        if (cmd.cmp_write && !sts.hit)
        begin
            w_reg <= w_reg + 1'b1;
        end
    end

    always_comb
    begin
        sts.addr_zero  = (addr_reg == '0);
        sts.is_wait    = (cmd_reg == OP_WAIT) || (cmd_reg == OP_WAIT_BITSET);
        sts.is_wake    = (cmd_reg == OP_WAKE) || (cmd_reg == OP_WAKE_BITSET)
                         || (cmd_reg == OP_REQUEUE);
        sts.val_eq     = (wval_reg == aval_reg);
        sts.full       = (occ_reg == CNT_W'(MAX_WAITERS));
        // The scan ends at the oldest entry or once the wake limit is met;
        // a limit of zero or below wakes nobody.
        sts.scan_done  = (i_reg == '0) || !(aval_reg > $signed(woken_wide));
        sts.hit        = (rd_addr_reg == addr_reg);
        sts.woken_zero = (woken_reg == '0);
        sts.cmp_done   = (r_reg == occ_reg);
    end

    // Result register: each result shows for exactly one cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= (cmd.emit != EM_NONE);
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.emit)
            EM_STATUS:
            begin
                rsp_reg.status      <= cmd.code;
                rsp_reg.task_valid  <= 1'b0;
                rsp_reg.woken_task  <= '0;
                rsp_reg.woken_count <= '0;
                rsp_reg.last        <= 1'b1;
            end
            EM_TASK:
            begin
                rsp_reg.status      <= ST_OK;
                rsp_reg.task_valid  <= 1'b1;
                rsp_reg.woken_task  <= rd_task_reg;
                rsp_reg.woken_count <= '0;
                rsp_reg.last        <= 1'b0;
            end
            EM_COUNT:
            begin
                rsp_reg.status      <= ST_OK;
                rsp_reg.task_valid  <= 1'b0;
                rsp_reg.woken_task  <= '0;
                rsp_reg.woken_count <= COUNT_W'(woken_reg);
                rsp_reg.last        <= 1'b1;
            end
            EM_NONE:
            begin
                rsp_reg <= rsp_reg;
            end
            default:
            begin
                rsp_reg <= rsp_reg;
            end
        endcase
    end

    assign valid = valid_reg;
    assign rsp   = rsp_reg;

endmodule

// ----- src/futex_wait_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// futex_wait_queue: bounded futex wait/wake queue engine
// Keeps an ordered table of waiting tasks keyed by futex word address,
// appends waiters and releases them newest first on a wake.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy then stays
// high until the request's final result has been produced. Results appear
// on rsp for exactly one cycle each, marked by valid, and cannot be held
// off, so the receiver must take every item in the cycle it shows. A
// wait, a rejected request or an unknown operation yields one item from
// the decode state and frees the block in the same cycle that the item
// shows. A wake yields one item per woken task, newest first, and then a
// final item with the count and last set. Its length is set by the waiter
// memory: the scan reads each entry visited and then checks it, from the
// newest down to the oldest woken one (or all entries if the limit is not
// met), and when anything was woken a compaction pass reads each entry and
// writes back each survivor from the lowest woken index to the top, between
// the decode and final states. The table needs no clearing after reset, so
// the block accepts items right away.
// ----------------------------------------------------------------------------
module futex_wait_queue #(
    parameter int MAX_WAITERS = 16,
    parameter int ADDR_BITS   = 48
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  fwq_pkg::req_t req,
    output logic          valid,
    output fwq_pkg::rsp_t rsp
);
    import fwq_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // The sequencer owns the protocol; the datapath only follows commands.
    fwq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .cmd   (cmd)
    );

    fwq_datapath #(
        .MAX_WAITERS (MAX_WAITERS),
        .ADDR_BITS   (ADDR_BITS)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .sts   (sts),
        .valid (valid),
        .rsp   (rsp)
    );

endmodule

// ----- src/fwq_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwq_checker: port-level checks of the futex wait queue
// Watches the request and result ports and flags sequencing slips.
// ----------------------------------------------------------------------------
module fwq_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input logic          busy,
    input logic          valid,
    input fwq_pkg::rsp_t rsp
);
    import fwq_pkg::*;

    // An accepted item keeps the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after accepting an item");

    // More results are still owed after a non-final item.
    a_more_follow: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && !rsp.last) |-> busy)
        else $error("block idle while a request is unfinished");

    // The block frees itself only together with a final result.
    a_free_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> (valid && rsp.last))
        else $error("block went idle without a final result");

    // A woken task item is a successful, non-final item with no count.
    a_task_item: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && rsp.task_valid) |->
            (rsp.status == ST_OK && rsp.woken_count == '0 && !rsp.last))
        else $error("malformed woken task item");

    // An error status ends the request at once.
    a_error_final: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && rsp.status != ST_OK) |-> (rsp.last && !rsp.task_valid))
        else $error("error status on a non-final item");

endmodule

bind futex_wait_queue fwq_checker u_fwq_checker (.*);

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the futex wait queue
// Drives wait, wake and other requests through the start/busy handshake with
// random idle gaps. An in-bench copy of the waiter table predicts every
// result item, and each observed item is checked field by field in order.
// ----------------------------------------------------------------------------
module testbench;

    import fwq_pkg::*;

    localparam int WAITER_SLOTS = 16;
    localparam int CYCLE_LIMIT  = 300000;
    // This drain window outlasts a full wake on a full table, so it
    // covers any item the block could still produce.
    localparam int DRAIN_CYCLES = 100;

    localparam logic [WORD_ADDR_W-1:0] ADDR_TOP = 48'hFFFF_FFFF_FFFF;
    localparam logic [WORD_ADDR_W-1:0] ADDR_ONE = 48'h1;
    localparam logic [WORD_ADDR_W-1:0] ADDR_MID = 48'h8000_0000_1000;
    // Any code that is neither a wait nor a wake is accepted as a no-op.
    localparam logic [CMD_W-1:0]       OP_NOP_TOP = 7'h7F;
    localparam logic [CMD_W-1:0]       OP_NOP_TWO = 7'd2;
    localparam logic [VALUE_W-1:0]     VAL_MIN = 32'h8000_0000;
    localparam logic [VALUE_W-1:0]     VAL_MAX = 32'h7FFF_FFFF;

    logic  clk;
    logic  rst_n;
    logic  start;
    logic  busy;
    req_t  req;
    logic  valid;
    rsp_t  rsp;

    futex_wait_queue dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .valid (valid),
        .rsp   (rsp)
    );

    // Requests waiting to be driven, and result items the table copy says
    // must come back, oldest first.
    req_t req_backlog[$];
    rsp_t rsp_due[$];

    // Bench copy of the waiter table: entry 0 is the oldest waiter.
    logic [WORD_ADDR_W-1:0] waiter_addr [WAITER_SLOTS];
    logic [TASK_W-1:0]      waiter_task [WAITER_SLOTS];
    int                     waiter_cnt;

    int fail_count;
    int cycle_count;
    int idle_left;
    int burst_left;
    int reqs_taken;
    int items_seen;
    int n_queued;
    int n_full;
    int n_again;
    int n_badaddr;
    int n_woken;
    int n_wakes;

    initial begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    // ------------------------------------------------------------------------
    // Prediction. Applies one accepted request to the table copy and queues
    // the result items it must produce. A wake walks from the newest entry
    // down, takes up to arg_value matching waiters, closes each hole so the
    // survivors keep their order, and ends with a count item.
    // ------------------------------------------------------------------------
    task automatic apply_futex_op(input req_t r);
        rsp_t item;
        int   limit;
        int   woken;
        int   i;
        int   j;
        item = '0;
        item.status = ST_OK;
        item.last = 1'b1;
        if (r.word_addr == '0) begin
            // Any operation on a null word is refused and leaves the table alone.
            item.status = ST_BADADDR;
            n_badaddr++;
            rsp_due.push_back(item);
            return;
        end
        if (r.cmd == OP_WAIT || r.cmd == OP_WAIT_BITSET) begin
            if (r.word_value != r.arg_value) begin
                item.status = ST_AGAIN;
                n_again++;
            end else if (waiter_cnt >= WAITER_SLOTS) begin
                item.status = ST_FULL;
                n_full++;
            end else begin
                waiter_addr[waiter_cnt] = r.word_addr;
                waiter_task[waiter_cnt] = r.caller_task;
                waiter_cnt++;
                n_queued++;
            end
            rsp_due.push_back(item);
            return;
        end
        if (r.cmd == OP_WAKE || r.cmd == OP_WAKE_BITSET || r.cmd == OP_REQUEUE) begin
            // A zero or negative argument wakes nobody.
            limit = (r.arg_value > 0) ? int'(r.arg_value) : 0;
            woken = 0;
            i = waiter_cnt;
            n_wakes++;
            while (i > 0 && woken < limit) begin
                i--;
                if (waiter_addr[i] == r.word_addr) begin
                    item = '0;
                    item.status = ST_OK;
                    item.task_valid = 1'b1;
                    item.woken_task = waiter_task[i];
                    rsp_due.push_back(item);
                    woken++;
                    for (j = i; j + 1 < waiter_cnt; j++) begin
                        waiter_addr[j] = waiter_addr[j + 1];
                        waiter_task[j] = waiter_task[j + 1];
                    end
                    waiter_cnt--;
                end
            end
            n_woken += woken;
            item = '0;
            item.status = ST_OK;
            item.woken_count = woken[COUNT_W-1:0];
            item.last = 1'b1;
        end
        rsp_due.push_back(item);
    endtask

    function automatic req_t make_req(input logic [CMD_W-1:0] cmd,
                                      input logic [WORD_ADDR_W-1:0] addr,
                                      input logic [VALUE_W-1:0] wval,
                                      input logic [VALUE_W-1:0] aval,
                                      input logic [TASK_W-1:0] who);
        req_t r;
        r.cmd = cmd;
        r.word_addr = addr;
        r.word_value = wval;
        r.arg_value = aval;
        r.caller_task = who;
        return r;
    endfunction

    // Idle time the driver leaves after an item: mostly none or a short
    // gap, now and then a long pause, and bursts with no gaps at all.
    function automatic int next_gap();
        int roll;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 15) begin
            burst_left = $urandom_range(8, 30);
            return 0;
        end
        if (roll < 80) begin
            return $urandom_range(0, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Driver. At each rising edge it notes whether the item on the port was
    // taken (start high, busy low), predicts that item, and then either
    // holds the port, idles, or puts up the next pending item. Each branch
    // gives start at most one nonblocking assignment, so a back-to-back item
    // keeps start high without a glitch.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin : drive_requests
        int gap;
        bit taken;
        if (!rst_n) begin
            start <= 1'b0;
            idle_left <= 0;
        end else begin
            taken = start && !busy;
            gap = idle_left;
            if (taken) begin
                apply_futex_op(req);
                reqs_taken++;
                gap = next_gap();
            end
            if (start && !taken) begin
                // The block is busy; the item stays on the port until taken.
            end else if (gap > 0) begin
                start <= 1'b0;
                idle_left <= gap - 1;
            end else if (req_backlog.size() > 0) begin
                start <= 1'b1;
                req <= req_backlog.pop_front();
                idle_left <= 0;
            end else begin
                start <= 1'b0;
                idle_left <= 0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor. Results cannot be held off, so every cycle with valid high
    // carries an item that is compared with the oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin : check_results
        rsp_t want;
        if (rst_n && valid === 1'b1) begin
            if (rsp_due.size() == 0) begin
                $error({"result item with none expected: status %0d task_valid %0d",
                        " task %0d count %0d last %0d"},
                       rsp.status, rsp.task_valid, rsp.woken_task, rsp.woken_count,
                       rsp.last);
                fail_count++;
            end else begin
                want = rsp_due.pop_front();
                check_field("status", want.status, rsp.status);
                check_field("task_valid", want.task_valid, rsp.task_valid);
                check_field("woken_task", want.woken_task, rsp.woken_task);
                check_field("woken_count", want.woken_count, rsp.woken_count);
                check_field("last", want.last, rsp.last);
                items_seen++;
            end
        end
    end

    // A hung block or a lost item ends the run here.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run. The directed part comes first: null words
    // with each kind of operation, a value mismatch, a wake on an empty
    // table, a no-op on a real word, sixteen waits that fill the table with
    // extreme values and task ids, a wait against the full table, wakes with
    // zero, negative, maximal and partial counts. The random part then
    // mostly runs well-formed wait groups on a few shared words, usually closed
    // by a wake, mixed with edge-case wakes and noise.
    // ------------------------------------------------------------------------
    initial begin : stimulus
        logic [WORD_ADDR_W-1:0] word_pool [4];
        logic [63:0]            wide;
        logic [VALUE_W-1:0]     val;
        logic [VALUE_W-1:0]     wake_arg;
        logic [CMD_W-1:0]       op;
        logic [WORD_ADDR_W-1:0] addr;
        int                     k;
        int                     group;
        int                     roll;
        int                     target;

        rst_n = 1'b0;
        start = 1'b0;
        req = '0;
        fail_count = 0;
        cycle_count = 0;
        idle_left = 0;
        burst_left = 0;
        reqs_taken = 0;
        items_seen = 0;
        n_queued = 0;
        n_full = 0;
        n_again = 0;
        n_badaddr = 0;
        n_woken = 0;
        n_wakes = 0;
        waiter_cnt = 0;
        for (k = 0; k < WAITER_SLOTS; k++) begin
            waiter_addr[k] = '0;
            waiter_task[k] = '0;
        end

        req_backlog.push_back(make_req(OP_WAIT, '0, 32'd5, 32'd5, 8'd1));
        req_backlog.push_back(make_req(OP_WAKE, '0, 32'd0, 32'd1, 8'd2));
        req_backlog.push_back(make_req(OP_NOP_TOP, '0, VAL_MAX, VAL_MIN, 8'd3));
        req_backlog.push_back(make_req(OP_WAIT_BITSET, ADDR_TOP, VAL_MIN, VAL_MAX, 8'd4));
        req_backlog.push_back(make_req(OP_WAKE, ADDR_TOP, 32'd0, 32'd5, 8'd5));
        req_backlog.push_back(make_req(OP_NOP_TWO, ADDR_ONE, 32'd0, 32'd0, 8'd6));
        for (k = 0; k < WAITER_SLOTS; k++) begin
            op = (k % 2 == 1) ? OP_WAIT_BITSET : OP_WAIT;
            addr = (k % 3 == 0) ? ADDR_ONE : ADDR_TOP;
            val = (k == 0) ? VAL_MIN : (k == 1) ? VAL_MAX : $urandom;
            req_backlog.push_back(make_req(op, addr, val, val,
                                           (k == 15) ? 8'hFF : 8'(k * 16)));
        end
        req_backlog.push_back(make_req(OP_WAIT, ADDR_MID, 32'd1, 32'd1, 8'd200));
        req_backlog.push_back(make_req(OP_WAKE, ADDR_TOP, 32'd0, 32'd0, 8'd7));
        req_backlog.push_back(make_req(OP_WAKE_BITSET, ADDR_TOP, 32'd0, VAL_MIN, 8'd8));
        req_backlog.push_back(make_req(OP_REQUEUE, ADDR_ONE, 32'd0, VAL_MAX, 8'd9));
        req_backlog.push_back(make_req(OP_WAKE, ADDR_TOP, 32'd0, 32'd2, 8'd10));
        req_backlog.push_back(make_req(OP_WAKE, ADDR_TOP, 32'd0, 32'd16, 8'd11));

        // A small pool of shared words keeps waits and wakes meeting often.
        word_pool[0] = ADDR_TOP;
        word_pool[1] = ADDR_ONE;
        for (k = 2; k < 4; k++) begin
            wide = {$urandom, $urandom};
            word_pool[k] = (wide[WORD_ADDR_W-1:0] == '0) ? ADDR_MID : wide[WORD_ADDR_W-1:0];
        end

        target = 430;
        while (req_backlog.size() < target) begin
            roll = $urandom_range(0, 99);
            if (roll < 60) begin
                // A group of matching waits, usually closed by a wake.
                if ($urandom_range(0, 9) == 0) begin
                    wide = {$urandom, $urandom};
                    word_pool[$urandom_range(2, 3)] = wide[WORD_ADDR_W-1:0] | 48'h1;
                end
                group = $urandom_range(1, 5);
                for (k = 0; k < group; k++) begin
                    val = $urandom;
                    op = $urandom_range(0, 1) ? OP_WAIT_BITSET : OP_WAIT;
                    req_backlog.push_back(make_req(op, word_pool[$urandom_range(0, 3)],
                                                   val, val, 8'($urandom_range(0, 255))));
                end
                if ($urandom_range(0, 9) < 7) begin
                    case ($urandom_range(0, 2))
                        0:       op = OP_WAKE;
                        1:       op = OP_WAKE_BITSET;
                        default: op = OP_REQUEUE;
                    endcase
                    wake_arg = ($urandom_range(0, 4) == 0) ? VAL_MAX
                                                           : 32'($urandom_range(1, group + 1));
                    req_backlog.push_back(make_req(op, word_pool[$urandom_range(0, 3)],
                                                   $urandom, wake_arg,
                                                   8'($urandom_range(0, 255))));
                end
            end else if (roll < 75) begin
                // A lone wake with an edge-case count.
                case ($urandom_range(0, 4))
                    0:       wake_arg = 32'd0;
                    1:       wake_arg = {1'b1, 31'($urandom)};
                    2:       wake_arg = VAL_MAX;
                    3:       wake_arg = $urandom;
                    default: wake_arg = 32'($urandom_range(1, 4));
                endcase
                case ($urandom_range(0, 2))
                    0:       op = OP_WAKE;
                    1:       op = OP_WAKE_BITSET;
                    default: op = OP_REQUEUE;
                endcase
                req_backlog.push_back(make_req(op, word_pool[$urandom_range(0, 3)],
                                               $urandom, wake_arg, 8'($urandom_range(0, 255))));
            end else if (roll < 83) begin
                // Null word with any code.
                req_backlog.push_back(make_req(7'($urandom_range(0, 127)), '0, $urandom,
                                               $urandom, 8'($urandom_range(0, 255))));
            end else if (roll < 91) begin
                // A wait whose value differs from the word in one random bit.
                val = $urandom;
                wake_arg = val ^ (32'h1 << $urandom_range(0, 31));
                op = $urandom_range(0, 1) ? OP_WAIT_BITSET : OP_WAIT;
                req_backlog.push_back(make_req(op, word_pool[$urandom_range(0, 3)], val,
                                               wake_arg, 8'($urandom_range(0, 255))));
            end else begin
                // Any code on a random word, most often a no-op.
                wide = {$urandom, $urandom};
                req_backlog.push_back(make_req(7'($urandom_range(0, 127)),
                                               wide[WORD_ADDR_W-1:0], $urandom, $urandom,
                                               8'($urandom_range(0, 255))));
            end
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Sample at the falling edge so the driver's updates have settled.
        @(negedge clk);
        while (req_backlog.size() != 0 || start || rsp_due.size() != 0) begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display({"Covered %0d requests: %0d waiters queued, %0d full,",
                  " %0d value mismatches, %0d null words."},
                 reqs_taken, n_queued, n_full, n_again, n_badaddr);
        $display("Checked %0d result items from %0d wakes that released %0d tasks.",
                 items_seen, n_wakes, n_woken);
        if (fail_count == 0 && rsp_due.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
src/fwq_pkg.sv
src/fwq_ctrl.sv
src/fwq_datapath.sv
src/futex_wait_queue.sv
src/fwq_checker.sv
sim/testbench.sv
